// ===== hdl/gbn_pkg.sv =====
package gbn_pkg;

  // Ring and window sizes; the usable window never reaches the whole ring.
  localparam int SEQ_COUNT = 20;
  localparam int WINDOW    = 10;
  localparam int USE_WIN   = (WINDOW < SEQ_COUNT - 1) ? WINDOW : SEQ_COUNT - 1;

  // Field widths fixed by the channel definitions.
  localparam int CMD_W  = 2;
  localparam int ACK_W  = 8;
  localparam int SEQ_W  = 5;
  localparam int PKT_W  = 16;
  localparam int LANE_W = (USE_WIN > 1) ? $clog2(USE_WIN) : 1;

  // Request command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_SEND    = 2'd1,
    CMD_ACK     = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_code_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_NEW  = 2'd1,
    KIND_RETX = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  // One result item.
  typedef struct packed {
    kind_t            kind;
    logic [SEQ_W-1:0] seq_number;
    logic [PKT_W-1:0] packet_number;
    logic             final_packet;
    logic             last;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic emit;
  } gbn_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
    logic tmo_start;
    logic emit_last;
  } gbn_status_t;

endpackage

// ===== hdl/gbn_channels.sv =====
// Request channel into the sender window.
interface gbn_in_if;
  import gbn_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [ACK_W-1:0] ack_number;
  logic             ack_final;
  modport source (output valid, command, ack_number, ack_final, input ready);
  modport sink   (input valid, command, ack_number, ack_final, output ready);
endinterface

// Result channel out of the sender window.
interface gbn_out_if;
  import gbn_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [SEQ_W-1:0] seq_number;
  logic [PKT_W-1:0] packet_number;
  logic             final_packet;
  logic             last;
  modport source (output valid, kind, seq_number, packet_number, final_packet, last,
                  input ready);
  modport sink   (input valid, kind, seq_number, packet_number, final_packet, last,
                  output ready);
endinterface

// Configuration write channel carrying the packet count.
interface gbn_cfg_if;
  import gbn_pkg::*;
  logic             valid;
  logic             ready;
  logic [PKT_W-1:0] total_packets;
  modport source (output valid, total_packets, input ready);
  modport sink   (input valid, total_packets, output ready);
endinterface

// ===== hdl/gbn_datapath.sv =====
module gbn_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gbn_pkg::gbn_cmd_t         ctrl,
  output gbn_pkg::gbn_status_t      st,
  input  logic [gbn_pkg::CMD_W-1:0] in_command,
  input  logic [gbn_pkg::ACK_W-1:0] in_ack_number,
  input  logic                      in_ack_final,
  input  logic                      cfg_we,
  input  logic [gbn_pkg::PKT_W-1:0] cfg_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output gbn_pkg::result_t          out_res
);
  import gbn_pkg::*;

  // Window state.
  logic [PKT_W-1:0]     total_r, total_nxt;
  logic [SEQ_W-1:0]     next_r, next_nxt;
  logic [SEQ_W-1:0]     base_r, base_nxt;
  logic [SEQ_COUNT-1:0] free_r, free_nxt;
  logic [PKT_W-1:0]     sent_r, sent_nxt;
  logic                 finished_r, finished_nxt;
  logic [USE_WIN-1:0]   mask_r, mask_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_res_r, out_res_nxt;

  // Decoded quantities.
  cmd_code_t            cmd;
  logic [SEQ_W-1:0]     outs;
  logic                 send_ok;
  logic [SEQ_W-1:0]     next_inc;
  logic [ACK_W-1:0]     ack_idx;
  logic [SEQ_W-1:0]     idx5;
  logic [SEQ_W-1:0]     ack_span;
  logic                 ack_ok;
  logic [SEQ_W-1:0]     base_ack;
  logic [SEQ_COUNT-1:0] free_ack;
  logic [SEQ_W-1:0]     off;
  logic [SEQ_W-1:0]     lane_slot [USE_WIN];
  logic [PKT_W-1:0]     lane_pkt  [USE_WIN];
  logic [SEQ_W:0]       lane_sum;
  logic [USE_WIN-1:0]   mask_calc;
  logic [LANE_W-1:0]    sel;
  logic                 emit_last;
  logic                 load_out;
  result_t              res;

  // True when the packet is the last of the transfer.
  function automatic logic is_final(input logic [PKT_W-1:0] pkt,
                                    input logic [PKT_W-1:0] total);
    logic [PKT_W:0] inc;
    inc = {1'b0, pkt} + (PKT_W+1)'(1);
    return inc == {1'b0, total};
  endfunction

  // Span, send and ack decoding.
  always_comb begin
    cmd      = cmd_code_t'(in_command);
    outs     = (next_r >= base_r) ? SEQ_W'(next_r - base_r)
                                  : SEQ_W'(next_r + SEQ_W'(SEQ_COUNT) - base_r);
    send_ok  = (outs < SEQ_W'(USE_WIN)) && free_r[next_r] && (sent_r < total_r);
    next_inc = (next_r == SEQ_W'(SEQ_COUNT - 1)) ? '0 : SEQ_W'(next_r + 1'b1);

    ack_idx  = in_ack_number - ACK_W'(1);
    idx5     = ack_idx[SEQ_W-1:0];
    ack_span = (idx5 >= base_r) ? SEQ_W'(idx5 - base_r)
                                : SEQ_W'(idx5 + SEQ_W'(SEQ_COUNT) - base_r);
    ack_ok   = (in_ack_number != '0) && (ack_idx < ACK_W'(SEQ_COUNT)) && (ack_span < outs);
    base_ack = (idx5 == SEQ_W'(SEQ_COUNT - 1)) ? '0 : SEQ_W'(idx5 + 1'b1);

    // Slots from the base up to the acked one are released together.
    free_ack = '0;
    off      = '0;
    for (int j = 0; j < SEQ_COUNT; j++) begin
      off = (SEQ_W'(j) >= base_r) ? SEQ_W'(SEQ_W'(j) - base_r)
                                  : SEQ_W'(SEQ_W'(j) + SEQ_W'(SEQ_COUNT) - base_r);
      free_ack[j] = (off <= ack_span);
    end
  end

  // Retransmission lanes, one per window position.
  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < USE_WIN; i++) begin
      lane_sum     = {1'b0, base_r} + (SEQ_W+1)'(i);
      lane_slot[i] = (lane_sum >= (SEQ_W+1)'(SEQ_COUNT))
                     ? SEQ_W'(lane_sum - (SEQ_W+1)'(SEQ_COUNT)) : lane_sum[SEQ_W-1:0];
      lane_pkt[i]  = PKT_W'(sent_r - PKT_W'(outs) + PKT_W'(i));
      mask_calc[i] = (SEQ_W'(i) < outs) && !free_r[lane_slot[i]] && (lane_pkt[i] < total_r);
    end
  end

  // Lowest pending lane and whether it is the final one.
  always_comb begin
    sel = '0;
    for (int i = USE_WIN - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = LANE_W'(i);
      end
    end
    emit_last = (mask_r & (mask_r - 1'b1)) == '0;
  end

  // Status back to the controller.
  always_comb begin
    st.out_free  = !out_valid_r || out_ready;
    st.tmo_start = (cmd == CMD_TIMEOUT) && !finished_r;
    st.emit_last = emit_last;
  end

  // Next state of the window and the result register.
  always_comb begin
    total_nxt    = total_r;
    next_nxt     = next_r;
    base_nxt     = base_r;
    free_nxt     = free_r;
    sent_nxt     = sent_r;
    finished_nxt = finished_r;
    mask_nxt     = mask_r;
    res          = '0;
    res.last     = 1'b1;

    if (cfg_we) begin
      total_nxt = cfg_data;
    end

    if (ctrl.accept) begin
      unique case (cmd)
        CMD_START: begin
          next_nxt     = '0;
          base_nxt     = '0;
          free_nxt     = '1;
          sent_nxt     = '0;
          finished_nxt = 1'b0;
        end
        CMD_SEND: begin
          if (!finished_r && send_ok) begin
            free_nxt[next_r]  = 1'b0;
            next_nxt          = next_inc;
            sent_nxt          = sent_r + PKT_W'(1);
            res.kind          = KIND_NEW;
            res.seq_number    = next_r;
            res.packet_number = sent_r;
            res.final_packet  = is_final(sent_r, total_r);
          end
        end
        CMD_ACK: begin
          if (!finished_r) begin
            if (in_ack_final) begin
              finished_nxt = 1'b1;
              res.kind     = KIND_DONE;
            end else if (ack_ok) begin
              free_nxt = free_r | free_ack;
              base_nxt = base_ack;
            end
          end
        end
        CMD_TIMEOUT: begin
          mask_nxt = mask_calc;
        end
        default: ;
      endcase
    end

    // One retransmission per emit step; an empty scan answers nothing sent.
    if (ctrl.emit) begin
      if (mask_r != '0) begin
        res.kind          = KIND_RETX;
        res.seq_number    = lane_slot[sel];
        res.packet_number = lane_pkt[sel];
        res.final_packet  = is_final(lane_pkt[sel], total_r);
        res.last          = emit_last;
      end
      mask_nxt = mask_r & (mask_r - 1'b1);
    end

    load_out      = (ctrl.accept && !st.tmo_start) || ctrl.emit;
    out_res_nxt   = load_out ? res : out_res_r;
    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      next_r      <= '0;
      base_r      <= '0;
      free_r      <= '1;
      sent_r      <= '0;
      finished_r  <= 1'b0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      next_r      <= next_nxt;
      base_r      <= base_nxt;
      free_r      <= free_nxt;
      sent_r      <= sent_nxt;
      finished_r  <= finished_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  // The outstanding span never grows past the usable window.
  a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outs <= SEQ_W'(USE_WIN))
    else $error("outstanding span exceeds the window");

  // A valid result always names a slot of the ring.
  a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.seq_number < SEQ_W'(SEQ_COUNT)))
    else $error("result slot outside the ring");
`endif

endmodule

// ===== hdl/gbn_ctrl.sv =====
module gbn_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gbn_pkg::gbn_status_t st,
  output gbn_pkg::gbn_cmd_t    ctrl
);
  import gbn_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Requests are taken only in idle and when the result register can be loaded.
  always_comb begin
    in_ready    = (state_r == ST_IDLE) && st.out_free;
    ctrl.accept = in_ready && in_valid;
    ctrl.emit   = (state_r == ST_EMIT) && st.out_free;
  end

  // A timeout walks its pending lanes before the next request.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctrl.accept && st.tmo_start) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (ctrl.emit && st.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // Emits only happen when the result register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> st.out_free)
    else $error("emit into a busy result register");

  // An accepted timeout always enters the emit walk.
  a_tmo_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.accept && st.tmo_start) |=> (state_r == ST_EMIT))
    else $error("timeout did not start the emit walk");

  // The final emit returns the controller to idle.
  a_emit_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.emit && st.emit_last) |=> (state_r == ST_IDLE))
    else $error("emit walk did not finish");
`endif

endmodule

// ===== hdl/go_back_n_send_window.sv =====
// Go-Back-N sender window over a ring of 20 sequence slots, window of 10.
// Requests arrive on in_if (command, ack_number, ack_final); results leave
// on out_if (kind, seq_number, packet_number, final_packet, last). The
// packet count is written through cfg_if, which is always ready; write it
// only while no request is in progress.
// Start, send and ack requests give one result each, which appears in the
// result register on the cycle after the request is taken.
// A timeout in a running transfer first captures the pending lanes, then
// one retransmission is issued per cycle while the result register is free,
// from the lowest window position upwards, with last on the final one; with
// no lane pending it gives a single empty result. Once the transfer is finished a
// timeout is answered like any other request.
// The result register is single; a new request is taken in the same cycle
// as the previous result leaves, so start, send and ack requests can stream
// at one per cycle while the receiver does not stall.
// When the receiver stalls, the result holds and no request is taken.
// Reset (rst_n low, synchronous) clears the window, marks every slot free,
// zeroes the packet count and empties the result register.
module go_back_n_send_window (
  input logic      clk,
  input logic      rst_n,
  gbn_in_if.sink   in_if,
  gbn_out_if.source out_if,
  gbn_cfg_if.sink  cfg_if
);
  import gbn_pkg::*;

  gbn_cmd_t    ctrl;
  gbn_status_t st;
  logic        in_ready;
  logic        out_valid;
  result_t     out_res;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .st       (st),
    .ctrl     (ctrl)
  );

  gbn_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .st            (st),
    .in_command    (in_if.command),
    .in_ack_number (in_if.ack_number),
    .in_ack_final  (in_if.ack_final),
    .cfg_we        (cfg_if.valid),
    .cfg_data      (cfg_if.total_packets),
    .out_ready     (out_if.ready),
    .out_valid     (out_valid),
    .out_res       (out_res)
  );

  // Channel wiring.
  assign in_if.ready          = in_ready;
  assign cfg_if.ready         = 1'b1;
  assign out_if.valid         = out_valid;
  assign out_if.kind          = out_res.kind;
  assign out_if.seq_number    = out_res.seq_number;
  assign out_if.packet_number = out_res.packet_number;
  assign out_if.final_packet  = out_res.final_packet;
  assign out_if.last          = out_res.last;

endmodule

// ===== bench/go_back_n_send_window_test.sv =====
`timescale 1ns / 100ps

module go_back_n_send_window_test;
  import gbn_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 43;
  localparam int N_ROWS = 23;

  localparam result_t IDLE_RES = '{KIND_NONE, 5'd0, 16'd0, 1'b0, 1'b1};
  localparam result_t DONE_RES = '{KIND_DONE, 5'd0, 16'd0, 1'b0, 1'b1};
  localparam result_t FIRST_RES = '{KIND_NEW, 5'd0, 16'd0, 1'b0, 1'b1};

  // One line of the directed script: either a packet count write or a request,
  // repeated reps times, with an optional result typed in by hand.
  typedef struct packed {
    logic             set_total;
    logic [PKT_W-1:0] total;
    cmd_code_t        cmd;
    logic [ACK_W-1:0] ack;
    logic             fin;
    logic [3:0]       reps;
    logic             typed;
    result_t          want;
  } script_row_t;

  localparam script_row_t SCRIPT [N_ROWS] = '{
    // With no packets in the transfer nothing can be sent or re-sent.
    '{1'b1, 16'd0,     CMD_START,   8'd0,   1'b0, 4'd1,  1'b0, IDLE_RES},
    '{1'b0, 16'd0,     CMD_SEND,    8'd0,   1'b0, 4'd1,  1'b1, IDLE_RES},
    '{1'b0, 16'd0,     CMD_TIMEOUT, 8'd0,   1'b0, 4'd1,  1'b1, IDLE_RES},
    '{1'b0, 16'd0,     CMD_ACK,     8'd0,   1'b0, 4'd1,  1'b1, IDLE_RES},
    // A three packet transfer: sends up to the count, stray acks, a partial ack.
    '{1'b1, 16'd3,     CMD_START,   8'd0,   1'b0, 4'd1,  1'b0, IDLE_RES},
    '{1'b0, 16'd0,     CMD_START,   8'd0,   1'b0, 4'd1,  1'b1, IDLE_RES},
    '{1'b0, 16'd0,     CMD_SEND,    8'd0,   1'b0, 4'd1,  1'b1, FIRST_RES},
    '{1'b0, 16'd0,     CMD_SEND,    8'd0,   1'b0, 4'd2,  1'b0, IDLE_RES},
    '{1'b0, 16'd0,     CMD_SEND,    8'd0,   1'b0, 4'd1,  1'b0, IDLE_RES},
    '{1'b0, 16'd0,     CMD_ACK,     8'd255, 1'b0, 4'd1,  1'b1, IDLE_RES},
    '{1'b0, 16'd0,     CMD_ACK,     8'd10,  1'b0, 4'd1,  1'b0, IDLE_RES},
    '{1'b0, 16'd0,     CMD_ACK,     8'd1,   1'b0, 4'd1,  1'b0, IDLE_RES},
    '{1'b0, 16'd0,     CMD_TIMEOUT, 8'd0,   1'b0, 4'd1,  1'b0, IDLE_RES},
    // Largest count: fill the window, try once more, then re-send all of it.
    '{1'b1, 16'hFFFF,  CMD_START,   8'd0,   1'b0, 4'd1,  1'b0, IDLE_RES},
    '{1'b0, 16'd0,     CMD_START,   8'd0,   1'b0, 4'd1,  1'b1, IDLE_RES},
    '{1'b0, 16'd0,     CMD_SEND,    8'd0,   1'b0, 4'd11, 1'b0, IDLE_RES},
    '{1'b0, 16'd0,     CMD_TIMEOUT, 8'd0,   1'b0, 4'd1,  1'b0, IDLE_RES},
    // Count lowered below what was sent, then the transfer is finished.
    '{1'b1, 16'd4,     CMD_START,   8'd0,   1'b0, 4'd1,  1'b0, IDLE_RES},
    '{1'b0, 16'd0,     CMD_TIMEOUT, 8'd0,   1'b0, 4'd1,  1'b0, IDLE_RES},
    '{1'b0, 16'd0,     CMD_SEND,    8'd0,   1'b0, 4'd1,  1'b0, IDLE_RES},
    '{1'b0, 16'd0,     CMD_ACK,     8'hA5,  1'b1, 4'd1,  1'b1, DONE_RES},
    '{1'b0, 16'd0,     CMD_SEND,    8'd0,   1'b0, 4'd1,  1'b1, IDLE_RES},
    '{1'b0, 16'd0,     CMD_START,   8'hFF,  1'b1, 4'd1,  1'b1, IDLE_RES}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gbn_in_if  in_ch ();
  gbn_out_if out_ch ();
  gbn_cfg_if cfg_ch ();

  go_back_n_send_window dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #5 clk = ~clk;

  // Predicted copy of the sender window.
  logic [SEQ_W-1:0]     win_next;
  logic [SEQ_W-1:0]     win_base;
  logic [SEQ_COUNT-1:0] slot_free;
  logic [PKT_W-1:0]     pkts_sent;
  logic [PKT_W-1:0]     pkt_total;
  logic                 xfer_done;

  result_t step_results [$];
  result_t owed_results [$];
  result_t head;
  int      faults = 0;
  int      quiet_cycles = 0;
  bit      calm = 1'b0;
  int      stall_left = 0;

  function automatic result_t make_result(kind_t k, int seq, int pkt, bit fin, bit last);
    result_t r;
    r.kind = k;
    r.seq_number = SEQ_W'(seq);
    r.packet_number = PKT_W'(pkt);
    r.final_packet = fin;
    r.last = last;
    return r;
  endfunction

  function automatic void clear_window();
    win_next = '0;
    win_base = '0;
    slot_free = '1;
    pkts_sent = '0;
    xfer_done = 1'b0;
  endfunction

  function automatic int in_flight();
    return (int'(win_next) + SEQ_COUNT - int'(win_base)) % SEQ_COUNT;
  endfunction

  // Works out the results of one request and moves the predicted window on.
  function automatic void window_step(cmd_code_t cmd, logic [ACK_W-1:0] ack, logic fin);
    int pkt;
    int s;
    int idx;
    int ack_span;
    int outs;
    step_results.delete();
    if (cmd == CMD_START) begin
      clear_window();
    end else if (xfer_done) begin
      // Everything but a start is ignored once the transfer is over.
    end else if (cmd == CMD_SEND) begin
      pkt = int'(pkts_sent);
      s = int'(win_next);
      if (in_flight() < USE_WIN && slot_free[s] && pkt < int'(pkt_total)) begin
        step_results.push_back(make_result(KIND_NEW, s, pkt, pkt + 1 == int'(pkt_total), 1'b1));
        slot_free[s] = 1'b0;
        win_next = SEQ_W'((s + 1) % SEQ_COUNT);
        pkts_sent = PKT_W'(pkt + 1);
      end
    end else if (cmd == CMD_ACK) begin
      if (fin) begin
        xfer_done = 1'b1;
        step_results.push_back(DONE_RES);
      end else if (ack != 0) begin
        // Cumulative ack: free every slot from the base up to the acked one.
        idx = int'(ack) - 1;
        if (idx < SEQ_COUNT) begin
          ack_span = (idx + SEQ_COUNT - int'(win_base)) % SEQ_COUNT;
          if (ack_span < in_flight()) begin
            for (int i = 0; i <= ack_span; i++)
              slot_free[(int'(win_base) + i) % SEQ_COUNT] = 1'b1;
            win_base = SEQ_W'((idx + 1) % SEQ_COUNT);
          end
        end
      end
    end else begin
      // Timeout: re-send every outstanding packet still inside the count.
      outs = in_flight();
      for (int i = 0; i < outs && i < USE_WIN; i++) begin
        s = (int'(win_base) + i) % SEQ_COUNT;
        pkt = (int'(pkts_sent) + 65536 - outs + i) & 16'hFFFF;
        if (!slot_free[s] && pkt < int'(pkt_total))
          step_results.push_back(make_result(KIND_RETX, s, pkt,
                                             pkt + 1 == int'(pkt_total), 1'b0));
      end
      if (step_results.size() != 0)
        step_results[step_results.size() - 1].last = 1'b1;
    end
    if (step_results.size() == 0)
      step_results.push_back(IDLE_RES);
  endfunction

  // Mostly short pauses, now and then a long one, none in calm phases.
  function automatic int pause_len();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endfunction

  // Drives one request, waits for it to be taken and records its results.
  task automatic issue(cmd_code_t cmd, logic [ACK_W-1:0] ack, logic fin, bit typed,
                       result_t want);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.ack_number <= ack;
    in_ch.ack_final <= fin;
    do @(posedge clk); while (!in_ch.ready);
    window_step(cmd, ack, fin);
    if (typed)
      owed_results.push_back(want);
    else
      foreach (step_results[i]) owed_results.push_back(step_results[i]);
  endtask

  // The packet count is only written once every owed result has come back.
  task automatic write_total(logic [PKT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.total_packets <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    pkt_total = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // One random request, biased towards sends and acks that land in the window.
  task automatic random_request();
    int r;
    cmd_code_t cmd;
    logic [ACK_W-1:0] ack;
    logic fin;
    r = $urandom_range(99);
    ack = ACK_W'($urandom_range(255));
    fin = 1'($urandom_range(1));
    if (xfer_done && $urandom_range(9) < 7) begin
      cmd = CMD_START;
    end else if (r < 45) begin
      cmd = CMD_SEND;
    end else if (r < 70) begin
      cmd = CMD_ACK;
      fin = 1'b0;
      if (in_flight() > 0)
        ack = ACK_W'((int'(win_base) + $urandom_range(in_flight() - 1)) % SEQ_COUNT + 1);
    end else if (r < 82) begin
      cmd = CMD_TIMEOUT;
    end else if (r < 93) begin
      // Broken acks: any byte at all, or one just past the outstanding span.
      cmd = CMD_ACK;
      fin = 1'b0;
      if (r >= 88)
        ack = ACK_W'(int'(win_next) + 1);
    end else if (r < 98) begin
      cmd = CMD_START;
    end else begin
      cmd = CMD_ACK;
      fin = 1'b1;
    end
    issue(cmd, ack, fin, 1'b0, IDLE_RES);
  endtask

  // Receiver side: held off during reset, then random back-pressure that is
  // absent in calm phases.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(99) < 20)
        stall_left <= pause_len();
    end
  end

  // Result checking and the watchdog on handshake activity.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result: kind %0d, seq_number %0d, packet_number %0d",
               out_ch.kind, out_ch.seq_number, out_ch.packet_number);
        faults++;
      end else begin
        head = owed_results.pop_front();
        check_field("kind", head.kind, out_ch.kind);
        check_field("seq_number", head.seq_number, out_ch.seq_number);
        check_field("packet_number", head.packet_number, out_ch.packet_number);
        check_field("final_packet", head.final_packet, out_ch.final_packet);
        check_field("last", head.last, out_ch.last);
      end
    end
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL go_back_n_send_window");
        $finish;
      end
    end
  end

  initial begin
    logic [PKT_W-1:0] phase_total;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_START;
    in_ch.ack_number <= '0;
    in_ch.ack_final <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.total_packets <= '0;
    clear_window();
    pkt_total = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script.
    for (int i = 0; i < N_ROWS; i++) begin
      if (SCRIPT[i].set_total)
        write_total(SCRIPT[i].total);
      else
        repeat (SCRIPT[i].reps)
          issue(SCRIPT[i].cmd, SCRIPT[i].ack, SCRIPT[i].fin, SCRIPT[i].typed, SCRIPT[i].want);
    end

    // Random phases, each under its own packet count; some keep the old window.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: phase_total = 16'd1;
        1: phase_total = 16'hFFFF;
        2: phase_total = 16'd0;
        3: phase_total = PKT_W'($urandom_range(40, 2));
        4: phase_total = 16'd12;
        5: phase_total = 16'd20;
        6: phase_total = PKT_W'($urandom_range(65535));
        default: phase_total = 16'hFFFF;
      endcase
      write_total(phase_total);
      calm = (p % 3 == 2);
      if (p == 0 || $urandom_range(1) == 1)
        issue(CMD_START, ACK_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, IDLE_RES);
      repeat (PHASE_ITEMS) random_request();
    end

    // Drain whatever is still owed, then allow for stray results.
    in_ch.valid <= 1'b0;
    calm = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (faults == 0 && owed_results.size() == 0)
      $display("PASS go_back_n_send_window");
    else
      $display("FAIL go_back_n_send_window");
    $finish;
  end

endmodule
